>>> rtl/rprle_pkg.sv
// Shared types and register indexes for the repeat-pair run-length decoder.
`timescale 1ns / 1ps
package rprle_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_OUTPUT_LIMIT    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GUARD_AFTER_RUN = 2'd1;

  typedef struct packed {
    logic [7:0]  prev_value;
    logic        expect_count;
    logic        run_guard;
    logic [15:0] bytes_written;
    logic        have_prev;
  } state_t;

  typedef struct packed {
    logic [3:0] pixel_high;
    logic [3:0] pixel_low;
    logic [7:0] repeat_length;
    logic       image_done;
  } result_t;

  localparam state_t STATE_CLEAR = '{
    prev_value:    8'd0,
    expect_count:  1'b0,
    run_guard:     1'b1,
    bytes_written: 16'd0,
    have_prev:     1'b0
  };

endpackage

>>> rtl/rprle_step.sv
// Decode step: next decoder state and fill command for one compressed byte.
`timescale 1ns / 1ps
module rprle_step (
  input  rprle_pkg::state_t  state_i,
  input  logic [7:0]         data_byte_i,
  input  logic               first_of_image_i,
  input  logic [15:0]        output_limit_i,
  input  logic               guard_after_run_i,
  output rprle_pkg::state_t  state_o,
  output logic               emit_o,
  output rprle_pkg::result_t result_o
);
  import rprle_pkg::*;

  state_t      cur;
  logic [15:0] remaining;
  logic [7:0]  run_len;
  logic [7:0]  value;
  logic [7:0]  length;
  logic [15:0] written_next;
  logic        blocked;

  always_comb begin
    cur          = first_of_image_i ? STATE_CLEAR : state_i;
    remaining    = output_limit_i - cur.bytes_written;
    run_len      = ((remaining[15:8] != 8'd0) || (data_byte_i < remaining[7:0])) ?
                   data_byte_i : remaining[7:0];
    blocked      = (guard_after_run_i && cur.run_guard) || !cur.have_prev;
    state_o      = cur;
    emit_o       = 1'b0;
    value        = data_byte_i;
    length       = 8'd1;
    if (cur.bytes_written < output_limit_i) begin
      if (cur.expect_count) begin
        state_o.expect_count = 1'b0;
        state_o.run_guard    = 1'b1;
        emit_o               = (data_byte_i != 8'd0);
        value                = cur.prev_value;
        length               = run_len;
      end else begin
        emit_o            = 1'b1;
        state_o.run_guard = 1'b0;
        if (!blocked && (data_byte_i == cur.prev_value)) begin
          state_o.expect_count = 1'b1;
        end else begin
          state_o.prev_value = data_byte_i;
          state_o.have_prev  = 1'b1;
        end
      end
    end
    written_next = cur.bytes_written + {8'd0, length};
    if (emit_o) begin
      state_o.bytes_written = written_next;
    end
    result_o.pixel_high    = value[7:4];
    result_o.pixel_low     = value[3:0];
    result_o.repeat_length = length;
    result_o.image_done    = (written_next >= output_limit_i);
  end

endmodule

>>> rtl/repeat_pair_rle_nibble_decoder_core.sv
// Top level: input word register, decode step and result register.
// An accepted input word is held in the input register, and its fill command in the result register.
// Throughput: one word per cycle while the output is not stalled; the input register
// and the result register each hold one word, so a stalled output takes one more word before ready falls.
// Reset: asynchronous, active low; clears both valid flags and the decoder state,
// output_limit to 0 and guard_after_run to 1.
`timescale 1ns / 1ps
module repeat_pair_rle_nibble_decoder_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       data_byte_i,
  input  logic                             first_of_image_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [3:0]                       pixel_high_o,
  output logic [3:0]                       pixel_low_o,
  output logic [7:0]                       repeat_length_o,
  output logic                             image_done_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rprle_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rprle_pkg::CfgDataW-1:0]   cfg_data_i
);
  import rprle_pkg::*;

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_first_q;
  logic        out_valid_q;
  result_t     result_q;
  state_t      state_q;
  state_t      state_d;
  logic [15:0] output_limit_q;
  logic        guard_after_run_q;
  logic        emit;
  result_t     result_d;
  logic        advance;

  assign cfg_ready_o = 1'b1;
  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;

  rprle_step u_step (
    .state_i           (state_q),
    .data_byte_i       (s1_byte_q),
    .first_of_image_i  (s1_first_q),
    .output_limit_i    (output_limit_q),
    .guard_after_run_i (guard_after_run_q),
    .state_o           (state_d),
    .emit_o            (emit),
    .result_o          (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      output_limit_q    <= 16'd0;
      guard_after_run_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_OUTPUT_LIMIT:    output_limit_q    <= cfg_data_i;
        REG_GUARD_AFTER_RUN: guard_after_run_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q  <= data_byte_i;
      s1_first_q <= first_of_image_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_high_o    = result_q.pixel_high;
  assign pixel_low_o     = result_q.pixel_low;
  assign repeat_length_o = result_q.repeat_length;
  assign image_done_o    = result_q.image_done;

`ifndef NO_ASSERTIONS
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (repeat_length_o != 8'd0))
    else $error("fill command with zero length");

  a_count_needs_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.expect_count |-> state_q.have_prev)
    else $error("run armed without a previous literal");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with empty input register");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(result_q)))
    else $error("pending fill command lost or changed");
`endif

endmodule

>>> tb/repeat_pair_rle_nibble_decoder_core_tb.sv
// Self-checking testbench for the repeat-pair run-length decoder, predicting each fill command.
`timescale 1ns / 1ps
module repeat_pair_rle_nibble_decoder_core_tb;
  import rprle_pkg::*;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 4;
  localparam logic [CfgIdxW-1:0] RegSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 2'd3;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic                in_ready_o;
  logic [7:0]          data_byte_i      = '0;
  logic                first_of_image_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i      = 1'b0;
  logic [3:0]          pixel_high_o;
  logic [3:0]          pixel_low_o;
  logic [7:0]          repeat_length_o;
  logic                image_done_o;
  logic                cfg_valid_i      = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i      = '0;
  logic [CfgDataW-1:0] cfg_data_i       = '0;

  repeat_pair_rle_nibble_decoder_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .first_of_image_i (first_of_image_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pixel_high_o     (pixel_high_o),
    .pixel_low_o      (pixel_low_o),
    .repeat_length_o  (repeat_length_o),
    .image_done_o     (image_done_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // decoder state and registers as predicted
  logic [7:0]  lit_prev;
  logic        count_due;
  logic        guard_set;
  logic [15:0] written;
  logic        lit_seen;
  logic [15:0] limit_reg;
  logic        guard_mode;

  result_t fill_q[$];
  int      errors      = 0;
  int      words_sent  = 0;
  int      words_used  = 0;
  int      fills_seen  = 0;
  int      cfg_writes  = 0;
  int      cycles      = 0;
  bit      no_idle     = 1'b0;

  function automatic void clear_image();
    lit_prev  = 8'd0;
    count_due = 1'b0;
    guard_set = 1'b1;
    written   = 16'd0;
    lit_seen  = 1'b0;
  endfunction

  function automatic bit decode_word(input logic [7:0] b, input logic first,
                                     output result_t fill, output bit ignored);
    logic [15:0] room;
    logic [7:0]  len;
    logic [7:0]  val;
    bit          blocked;
    fill    = '0;
    ignored = 1'b0;
    if (first) clear_image();
    if (written >= limit_reg) begin
      ignored = 1'b1;
      return 1'b0;
    end
    if (count_due) begin
      count_due = 1'b0;
      guard_set = 1'b1;
      if (b == 8'd0) return 1'b0;
      room = limit_reg - written;
      len  = ({8'd0, b} < room) ? b : room[7:0];
      val  = lit_prev;
    end else begin
      blocked   = (guard_mode && guard_set) || !lit_seen;
      guard_set = 1'b0;
      if (!blocked && b == lit_prev) begin
        count_due = 1'b1;
      end else begin
        lit_prev = b;
        lit_seen = 1'b1;
      end
      len = 8'd1;
      val = b;
    end
    written            = written + {8'd0, len};
    fill.pixel_high    = val[7:4];
    fill.pixel_low     = val[3:0];
    fill.repeat_length = len;
    fill.image_done    = (written >= limit_reg);
    return 1'b1;
  endfunction

  task automatic send_word(input logic [7:0] b, input logic first);
    result_t fill;
    bit      ignored;
    while (!no_idle && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    data_byte_i      <= b;
    first_of_image_i <= first;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    if (decode_word(b, first, fill, ignored)) fill_q.push_back(fill);
    if (!ignored) words_used++;
  endtask

  // drop valid, wait for every fill command and let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (fill_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_OUTPUT_LIMIT:    limit_reg  = value;
      REG_GUARD_AFTER_RUN: guard_mode = value[0];
      default: ;
    endcase
  endtask

  task automatic set_mode(input logic [15:0] lim, input logic guard);
    write_reg(REG_OUTPUT_LIMIT, lim);
    write_reg(REG_GUARD_AFTER_RUN, {15'($urandom), guard});
  endtask

  task automatic test_reset_defaults();
    send_word(8'h3C, 1'b1);
    send_word(8'h3C, 1'b0);
  endtask

  task automatic test_guarded_runs();
    set_mode(16'd40, 1'b1);
    send_word(8'h00, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h03, 1'b0);
    send_word(8'h5A, 1'b0);
    send_word(8'h5A, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h12, 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'h01, 1'b0);
  endtask

  task automatic test_open_runs();
    set_mode(16'hFF00, 1'b0);
    send_word(8'hC3, 1'b1);
    send_word(8'hC3, 1'b0);
    send_word(8'h02, 1'b0);
    send_word(8'hC3, 1'b0);
    send_word(8'h04, 1'b0);
    send_word(8'h7E, 1'b0);
  endtask

  task automatic test_limit_lowered();
    set_mode(16'd100, 1'b1);
    write_reg(RegSpareLo, 16'($urandom));
    write_reg(RegSpareHi, 16'($urandom));
    send_word(8'h11, 1'b1);
    send_word(8'h22, 1'b0);
    send_word(8'h22, 1'b0);
    send_word(8'h30, 1'b0);
    write_reg(REG_OUTPUT_LIMIT, 16'd20);
    send_word(8'h44, 1'b0);
    send_word(8'h44, 1'b1);
  endtask

  task automatic test_random_images(input int n, input bit big_runs);
    int         target;
    int         pick;
    bit         start;
    logic [7:0] v;
    logic [7:0] cnt;
    target = words_used + n;
    start  = 1'b1;
    while (words_used < target) begin
      pick = $urandom_range(99);
      if (written >= limit_reg && !start) begin
        if (pick < 10) send_word(8'($urandom_range(255)), 1'b0);
        else start = 1'b1;
      end else if (pick < 60) begin
        v    = (pick < 15 && lit_seen) ? lit_prev : 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (big_runs) cnt = (pick < 80) ? 8'hFF : 8'($urandom_range(255));
        else if (pick < 10) cnt = 8'h00;
        else if (pick < 20) cnt = 8'hFF;
        else cnt = 8'($urandom_range(255));
        send_word(v, start);
        send_word(v, 1'b0);
        send_word(cnt, 1'b0);
        start = 1'b0;
      end else if (pick < 93) begin
        send_word(8'($urandom_range(255)), start);
        start = 1'b0;
      end else begin
        send_word(8'($urandom_range(255)), 1'b1);
        start = 1'b0;
      end
    end
  endtask

  always @(posedge clk_i) begin : fill_check
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{pixel_high_o, pixel_low_o, repeat_length_o, image_done_o};
      fills_seen++;
      if (fill_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected fill command, expected none, got hi=%h lo=%h len=%0d done=%b",
                 $time, got.pixel_high, got.pixel_low, got.repeat_length, got.image_done);
      end else begin
        want = fill_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: fill mismatch, expected hi=%h lo=%h len=%0d done=%b, got hi=%h lo=%h len=%0d done=%b",
                   $time, want.pixel_high, want.pixel_low, want.repeat_length, want.image_done,
                   got.pixel_high, got.pixel_low, got.repeat_length, got.image_done);
        end
      end
    end
    out_ready_i <= no_idle || ($urandom_range(99) >= 9);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    clear_image();
    limit_reg  = 16'd0;
    guard_mode = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_guarded_runs();
    test_open_runs();
    test_limit_lowered();

    set_mode(16'hFF00, 1'b1);
    test_random_images(800, 1'b1);
    set_mode(16'd200, 1'b0);
    no_idle = 1'b1;
    test_random_images(300, 1'b0);
    no_idle = 1'b0;
    set_mode(16'($urandom_range(600, 1)), 1'b1);
    test_random_images(300, 1'b0);
    set_mode(16'd1, 1'b0);
    test_random_images(100, 1'b0);
    set_mode(16'($urandom_range(65280, 1)), 1'($urandom_range(1)));
    test_random_images(300, 1'b0);

    settle();
    $display("Sent %0d input words (%0d decoded) over %0d register writes, guard on and off,",
             words_sent, words_used, cfg_writes);
    $display("limits from 0 to 0xFF00; checked %0d fill commands, %0d mismatches",
             fills_seen, errors);
    if (errors == 0 && fill_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
